// ===== rtl/core/mtt_pkg.sv =====
// Shared widths, codes and state encoding for the encoder turn tracker.
package mtt_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int TURN_BITS  = 16;
	localparam int TOL_BITS   = 8;
	localparam int RATE_BITS  = 16;
	localparam int CFG_BITS   = 2;
	localparam int QUAD_BITS  = 3;
	localparam int RATE_OUT_BITS = 32;
	localparam int TOTAL_BITS = TURN_BITS + ANGLE_BITS + 1;
	localparam int OP_BITS    = (TOTAL_BITS + 1 > RATE_OUT_BITS + 1) ? TOTAL_BITS + 1
	                                                                  : RATE_OUT_BITS + 1;
	localparam int PROD_BITS  = OP_BITS + RATE_BITS + 1;

	localparam logic [ANGLE_BITS-1:0] HOME_POS_RST = '0;
	localparam logic [TOL_BITS-1:0]   HOME_TOL_RST = TOL_BITS'(6);
	localparam logic [RATE_BITS-1:0]  RATE_RST     = RATE_BITS'(20);

	typedef enum logic [CFG_BITS-1:0] {
		CFG_HOME_POS = 2'd0,
		CFG_HOME_TOL = 2'd1,
		CFG_RATE     = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ABSENT    = 2'd1,
		ST_NOT_HOMED = 2'd2,
		ST_REJECTED  = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EVAL = 8'b0000_0010,
		S_TOT  = 8'b0000_0100,
		S_MV   = 8'b0000_1000,
		S_VEL  = 8'b0001_0000,
		S_MA   = 8'b0010_0000,
		S_ACC  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic signed [OP_BITS-1:0] op_a;
		logic [RATE_BITS-1:0]      rate;
	} mul_req_t;

endpackage

// ===== rtl/core/mtt_mul.sv =====
// Shared rate multiplier with 32-bit signed saturation and registered result.
module mtt_mul
	import mtt_pkg::*;
(
	input  logic                            clk,
	input  mtt_pkg::mul_req_t               req,
	output logic signed [RATE_OUT_BITS-1:0] res_q
);

	logic signed [PROD_BITS-1:0] prod;
	logic                        ovf;

	assign prod = PROD_BITS'(req.op_a) * $signed({1'b0, req.rate});
	assign ovf  = (prod[PROD_BITS-1:RATE_OUT_BITS-1] != '0) &&
	              (prod[PROD_BITS-1:RATE_OUT_BITS-1] != '1);

	always_ff @(posedge clk) begin
		if (ovf) begin
			res_q <= prod[PROD_BITS-1] ? {1'b1, {(RATE_OUT_BITS-1){1'b0}}}
			                           : {1'b0, {(RATE_OUT_BITS-1){1'b1}}};
		end else begin
			res_q <= prod[RATE_OUT_BITS-1:0];
		end
	end

endmodule

// ===== rtl/core/magnetic_encoder_turn_tracker_top.sv =====
// Encoder turn tracker: homing, turn counting, total angle, velocity and acceleration.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid / in_stall  | func, raw_angle, sensor_present
//   out     | source    | out_valid / out_stall| status, is_homed, position, total_angle,
//           |           |                      | velocity, acceleration
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An update runs S_EVAL, S_TOT, S_MV, S_VEL, S_MA, S_ACC, S_DONE; a failed step or homing
// goes from S_EVAL to S_DONE. The shared multiplier is used twice: velocity, acceleration.
// in_stall is high from the input transfer until the result is loaded into the output
// register, so the next item can be taken while a result waits on out_stall.
// arst_n clears all control and tracking state; cfg_ready is always high.
module magnetic_encoder_turn_tracker_top
	import mtt_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [ANGLE_BITS-1:0]           raw_angle,
	input  logic                            sensor_present,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic                            is_homed,
	output logic [ANGLE_BITS-1:0]           position,
	output logic signed [TOTAL_BITS-1:0]    total_angle,
	output logic signed [RATE_OUT_BITS-1:0] velocity,
	output logic signed [RATE_OUT_BITS-1:0] acceleration,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [CFG_BITS-1:0]             cfg_index,
	input  logic [RATE_BITS-1:0]            cfg_data
);

	state_t                          state_q;
	logic                            func_q;
	logic [ANGLE_BITS-1:0]           raw_q;
	logic                            present_q;
	logic [ANGLE_BITS-1:0]           home_pos_q;
	logic [TOL_BITS-1:0]             home_tol_q;
	logic [RATE_BITS-1:0]            rate_q;
	logic                            homed_q;
	logic [ANGLE_BITS-1:0]           offset_q;
	logic [ANGLE_BITS-1:0]           rel_q;
	logic [QUAD_BITS-1:0]            quad_q;
	logic signed [TURN_BITS-1:0]     turn_q;
	logic signed [TOTAL_BITS-1:0]    total_q;
	logic signed [RATE_OUT_BITS-1:0] vel_q;
	logic signed [RATE_OUT_BITS-1:0] acc_q;
	status_t                         stat_q;
	logic signed [OP_BITS-1:0]       op_a_q;
	logic                            out_valid_q;

	logic [ANGLE_BITS-1:0]           home_gap;
	logic [QUAD_BITS-1:0]            quad;
	logic signed [TOTAL_BITS-1:0]    new_total;
	logic signed [OP_BITS-1:0]       delta;
	logic signed [OP_BITS-1:0]       vel_diff;
	logic signed [RATE_OUT_BITS-1:0] mul_res;
	logic                            in_xfer;
	logic                            cfg_xfer;
	logic                            load_out;
	mul_req_t                        mul_req;

	localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
	localparam logic [QUAD_BITS-1:0] QUAD_FIRST = QUAD_BITS'(1);
	localparam logic [QUAD_BITS-1:0] QUAD_LAST  = QUAD_BITS'(4);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign home_gap  = (raw_q > home_pos_q) ? raw_q - home_pos_q : home_pos_q - raw_q;
	assign quad      = {1'b0, raw_q[ANGLE_BITS-1 -: 2]} + QUAD_FIRST;
	assign new_total = {turn_q[TURN_BITS-1], turn_q, raw_q};
	assign delta     = OP_BITS'(new_total) - OP_BITS'(total_q);
	assign vel_diff  = OP_BITS'(mul_res) - OP_BITS'(vel_q);

	assign mul_req.op_a = op_a_q;
	assign mul_req.rate = rate_q;

	mtt_mul u_mul (
		.clk   (clk),
		.req   (mul_req),
		.res_q (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			home_pos_q  <= HOME_POS_RST;
			home_tol_q  <= HOME_TOL_RST;
			rate_q      <= RATE_RST;
			homed_q     <= 1'b0;
			offset_q    <= '0;
			rel_q       <= '0;
			quad_q      <= '0;
			turn_q      <= '0;
			total_q     <= '0;
			vel_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_xfer) begin
				case (cfg_index)
					CFG_HOME_POS: begin
						home_pos_q <= cfg_data[ANGLE_BITS-1:0];
						homed_q    <= 1'b0;
					end
					CFG_HOME_TOL: home_tol_q <= cfg_data[TOL_BITS-1:0];
					CFG_RATE:     rate_q     <= cfg_data;
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!func_q) begin
						if (home_gap > ANGLE_BITS'(home_tol_q)) begin
							homed_q <= 1'b0;
						end else begin
							homed_q  <= 1'b1;
							offset_q <= raw_q;
							rel_q    <= '0;
						end
						state_q <= S_DONE;
					end else if (!present_q || !homed_q) begin
						state_q <= S_DONE;
					end else begin
						rel_q <= raw_q - offset_q;
						if (quad != quad_q) begin
							if (quad == QUAD_FIRST && quad_q == QUAD_LAST) begin
								if (turn_q != TURN_MAX) begin
									turn_q <= turn_q + TURN_BITS'(1);
								end
							end else if (quad == QUAD_LAST && quad_q == QUAD_FIRST) begin
								if (turn_q != TURN_MIN) begin
									turn_q <= turn_q - TURN_BITS'(1);
								end
							end
							quad_q <= quad;
						end
						state_q <= S_TOT;
					end
				end
				S_TOT: begin
					total_q <= new_total;
					state_q <= S_MV;
				end
				S_MV: begin
					state_q <= S_VEL;
				end
				S_VEL: begin
					vel_q   <= mul_res;
					state_q <= S_MA;
				end
				S_MA: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= mul_res;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q    <= func;
			raw_q     <= raw_angle;
			present_q <= sensor_present;
		end
		if (state_q == S_EVAL) begin
			if (!func_q) begin
				stat_q <= (home_gap > ANGLE_BITS'(home_tol_q)) ? ST_REJECTED : ST_OK;
			end else if (!present_q) begin
				stat_q <= ST_ABSENT;
			end else if (!homed_q) begin
				stat_q <= ST_NOT_HOMED;
			end else begin
				stat_q <= ST_OK;
			end
		end
		if (state_q == S_TOT) begin
			op_a_q <= delta;
		end else if (state_q == S_VEL) begin
			op_a_q <= vel_diff;
		end
		if (load_out) begin
			status       <= stat_q;
			is_homed     <= homed_q;
			position     <= rel_q;
			total_angle  <= total_q;
			velocity     <= vel_q;
			acceleration <= acc_q;
		end
	end

	assign out_valid = out_valid_q;

	a_home_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_xfer && cfg_index == CFG_HOME_POS && state_q == S_IDLE |=> !homed_q)
		else $error("home position write did not clear homed flag");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_EVAL)
		else $error("accepted item did not enter evaluation");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && state_q == S_IDLE)
		else $error("result load did not raise out_valid");

	a_total_only_in_tot: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(total_q) |-> $past(state_q) == S_TOT)
		else $error("total position changed outside its step");

endmodule
